// ===== rtl/core/look_at_view_matrix_top_assert.svh =====
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LAV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lav_pkg.sv =====
// Package with the payload types and constants of the look-at view matrix block.
package lav_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] COL_LAST = 2'd3;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] eye_x;
        logic signed [WORD_BITS-1:0] eye_y;
        logic signed [WORD_BITS-1:0] eye_z;
        logic signed [WORD_BITS-1:0] center_x;
        logic signed [WORD_BITS-1:0] center_y;
        logic signed [WORD_BITS-1:0] center_z;
        logic signed [WORD_BITS-1:0] up_x;
        logic signed [WORD_BITS-1:0] up_y;
        logic signed [WORD_BITS-1:0] up_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  column_index;
        logic signed [WORD_BITS-1:0] entry_row0;
        logic signed [WORD_BITS-1:0] entry_row1;
        logic signed [WORD_BITS-1:0] entry_row2;
        logic signed [WORD_BITS-1:0] entry_row3;
        logic                        degenerate;
        logic                        last_column;
    } t_out_item;

endpackage

// ===== rtl/core/lav_stream_if.sv =====
// Valid/ready stream interface that carries one payload per transfer.
interface lav_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/look_at_view_matrix_top.sv =====
// Look-at view matrix pipeline: eye, center and up in, four matrix columns out.
//
// The input channel i_item takes one transfer per camera: eye, center and up
// as nine signed Q16.16 words. For each camera the output channel o_col gives
// four transfers, columns 0 to 3 of the column-major view matrix, with the
// column number, a degenerate flag that is the same on all four, and a last
// column mark on column 3.
// The work runs through a 117-stage pipeline: the forward vector is
// normalized, the side vector is formed and normalized, then the up vector
// and the eye dot products follow. Each normalization has a shared shift
// stage set, a square root that resolves one result bit per stage and three
// dividers that resolve one quotient bit per stage. Columns leave the output
// register one per cycle while the receiver is ready. The single output port
// takes four transfers per camera; a new camera is taken while earlier ones
// are still in flight. When the output register cannot take the last stage's
// camera, the whole pipeline holds in place and i_item.ready drops. Reset
// empties every stage and the output register; no clearing pass.
`include "look_at_view_matrix_top_assert.svh"

module look_at_view_matrix_top
    import lav_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lav_stream_if.sink    i_item,
    lav_stream_if.source  o_col
);

    localparam int MW    = 49;
    localparam int VW    = 19;
    localparam int PW    = 52;
    localparam int AW    = 54;
    localparam int N_LEN = 55;
    localparam int NF    = 1;
    localparam int SP    = NF + N_LEN;
    localparam int SD    = SP + 1;
    localparam int NS    = SD + 1;
    localparam int UP    = NS + N_LEN;
    localparam int UC    = UP + 1;
    localparam int DP    = UC + 1;
    localparam int DC    = DP + 1;
    localparam int LAST  = DC;

    localparam logic [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] eye;
        logic [2:0][WORD_BITS-1:0] up;
        logic [2:0][MW-1:0]        mag;
        logic [2:0]                neg;
        logic [2:0][59:0]          sq;
        logic [62:0]               sv;
        logic [62:0]               sr;
        logic [30:0]               len;
        logic [2:0][46:0]          num;
        logic [2:0][32:0]          drem;
        logic [2:0][16:0]          quo;
        logic                      zero;
        logic                      degen;
        logic [2:0][VW-1:0]        f;
        logic [2:0][VW-1:0]        s;
        logic [2:0][VW-1:0]        u;
        logic [8:0][PW-1:0]        prod;
        logic [2:0][WORD_BITS-1:0] dot;
    } t_pipe;

    function automatic logic signed [PW-1:0] mul(input logic signed [VW-1:0] a,
                                                 input logic signed [WORD_BITS-1:0] b);
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] be;
        ae = PW'(a);
        be = PW'(b);
        return ae * be;
    endfunction

    function automatic logic signed [AW-1:0] shr_rnd(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        m = (m + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[AW-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [WORD_BITS-1:0] sat_w(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
        lo = -hi - AW'(1);
        if (v > hi) begin
            return hi[WORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[WORD_BITS-1:0];
        end
        return v[WORD_BITS-1:0];
    endfunction

    function automatic t_pipe stage_op(input int k, input t_pipe p);
        t_pipe                q;
        int                   j;
        int                   it;
        int                   amt;
        logic [MW-1:0]        orv;
        logic [29:0]          top;
        logic [62:0]          b;
        logic [32:0]          t;
        logic [VW-1:0]        nv;
        logic signed [AW-1:0] acc;
        q = p;
        if (k >= NF && k < NF + N_LEN) begin
            j = k - NF;
        end else if (k >= NS && k < NS + N_LEN) begin
            j = k - NS;
        end else begin
            j = -1;
        end
        if (j >= 0 && j < 3) begin
            amt = 32 >> (2 * j);
            for (int st = 0; st < 2; st++) begin
                orv = q.mag[0] | q.mag[1] | q.mag[2];
                if ((orv >> (MW - amt)) == '0) begin
                    for (int c = 0; c < 3; c++) q.mag[c] = q.mag[c] << amt;
                end
                amt = amt / 2;
            end
        end else if (j == 3) begin
            orv = p.mag[0] | p.mag[1] | p.mag[2];
            q.zero = (orv == '0);
            for (int c = 0; c < 3; c++) begin
                top = p.mag[c][MW-1 -: 30];
                q.sq[c] = {30'b0, top} * {30'b0, top};
            end
        end else if (j == 4) begin
            q.sv = 63'(p.sq[0]) + 63'(p.sq[1]) + 63'(p.sq[2]);
            q.sr = '0;
        end else if (j >= 5 && j < 36) begin
            it = 30 - (j - 5);
            b = 63'(1) << (2 * it);
            if (p.sv >= p.sr + b) begin
                q.sv = p.sv - (p.sr + b);
                q.sr = (p.sr >> 1) + b;
            end else begin
                q.sr = p.sr >> 1;
            end
        end else if (j == 36) begin
            q.len = p.sr[30:0];
            for (int c = 0; c < 3; c++) begin
                top = p.mag[c][MW-1 -: 30];
                q.num[c] = 47'({top, {FRAC_BITS{1'b0}}}) + 47'(p.sr[30:1]);
                q.drem[c] = 33'(q.num[c] >> 17);
                q.quo[c] = '0;
            end
        end else if (j >= 37 && j < 54) begin
            it = 16 - (j - 37);
            for (int c = 0; c < 3; c++) begin
                t = {p.drem[c][31:0], p.num[c][it]};
                if (t >= {2'b0, p.len}) begin
                    q.drem[c] = t - {2'b0, p.len};
                    q.quo[c][it] = 1'b1;
                end else begin
                    q.drem[c] = t;
                end
            end
        end else if (j == 54) begin
            for (int c = 0; c < 3; c++) begin
                if (p.zero) begin
                    nv = '0;
                end else if (p.neg[c]) begin
                    nv = -{2'b0, p.quo[c]};
                end else begin
                    nv = {2'b0, p.quo[c]};
                end
                if (k < NS) begin
                    q.f[c] = nv;
                end else begin
                    q.s[c] = nv;
                end
            end
            q.degen = p.degen | p.zero;
        end else if (k == SP) begin
            q.prod[0] = mul(p.f[1], p.up[2]);
            q.prod[1] = mul(p.f[2], p.up[1]);
            q.prod[2] = mul(p.f[2], p.up[0]);
            q.prod[3] = mul(p.f[0], p.up[2]);
            q.prod[4] = mul(p.f[0], p.up[1]);
            q.prod[5] = mul(p.f[1], p.up[0]);
        end else if (k == SD) begin
            for (int c = 0; c < 3; c++) begin
                acc = AW'($signed(p.prod[2*c])) - AW'($signed(p.prod[2*c+1]));
                q.neg[c] = acc[AW-1];
                q.mag[c] = acc[AW-1] ? MW'(-acc) : MW'(acc);
            end
        end else if (k == UP) begin
            q.prod[0] = mul(p.s[1], WORD_BITS'($signed(p.f[2])));
            q.prod[1] = mul(p.s[2], WORD_BITS'($signed(p.f[1])));
            q.prod[2] = mul(p.s[2], WORD_BITS'($signed(p.f[0])));
            q.prod[3] = mul(p.s[0], WORD_BITS'($signed(p.f[2])));
            q.prod[4] = mul(p.s[0], WORD_BITS'($signed(p.f[1])));
            q.prod[5] = mul(p.s[1], WORD_BITS'($signed(p.f[0])));
        end else if (k == UC) begin
            for (int c = 0; c < 3; c++) begin
                acc = AW'($signed(p.prod[2*c])) - AW'($signed(p.prod[2*c+1]));
                q.u[c] = VW'(shr_rnd(acc));
            end
        end else if (k == DP) begin
            for (int c = 0; c < 3; c++) begin
                q.prod[c]   = mul(p.s[c], p.eye[c]);
                q.prod[3+c] = mul(p.u[c], p.eye[c]);
                q.prod[6+c] = mul(p.f[c], p.eye[c]);
            end
        end else if (k == DC) begin
            for (int d = 0; d < 3; d++) begin
                acc = AW'($signed(p.prod[3*d])) + AW'($signed(p.prod[3*d+1]))
                    + AW'($signed(p.prod[3*d+2]));
                acc = shr_rnd(acc);
                q.dot[d] = (d == 2) ? sat_w(acc) : sat_w(-acc);
            end
        end
        return q;
    endfunction

    t_pipe            r_pipe [0:LAST];
    t_pipe            n_pipe [0:LAST];
    logic [LAST:0]    r_vld;
    t_pipe            r_res;
    logic [1:0]       r_col;
    logic             r_busy;
    logic             en;
    logic             ser_load;
    logic signed [32:0] fr [3];

    assign ser_load = r_vld[LAST] && (!r_busy || (o_col.ready && r_col == COL_LAST));
    assign en = !r_vld[LAST] || ser_load;
    assign i_item.ready = en;

    always_comb begin
        fr[0] = 33'(i_item.payload.center_x) - 33'(i_item.payload.eye_x);
        fr[1] = 33'(i_item.payload.center_y) - 33'(i_item.payload.eye_y);
        fr[2] = 33'(i_item.payload.center_z) - 33'(i_item.payload.eye_z);
        n_pipe[0] = '0;
        n_pipe[0].eye[0] = i_item.payload.eye_x;
        n_pipe[0].eye[1] = i_item.payload.eye_y;
        n_pipe[0].eye[2] = i_item.payload.eye_z;
        n_pipe[0].up[0]  = i_item.payload.up_x;
        n_pipe[0].up[1]  = i_item.payload.up_y;
        n_pipe[0].up[2]  = i_item.payload.up_z;
        for (int c = 0; c < 3; c++) begin
            n_pipe[0].neg[c] = fr[c][32];
            n_pipe[0].mag[c] = fr[c][32] ? MW'(-fr[c]) : MW'(fr[c]);
        end
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        assign n_pipe[k] = stage_op(k, r_pipe[k-1]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= LAST; k++) r_pipe[k] <= n_pipe[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_res <= r_pipe[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
        end else if (ser_load) begin
            r_busy <= 1'b1;
            r_col  <= '0;
        end else if (o_col.valid && o_col.ready) begin
            r_col <= r_col + 2'd1;
            if (r_col == COL_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_col.valid = r_busy;

    always_comb begin
        o_col.payload.column_index = r_col;
        o_col.payload.degenerate   = r_res.degen;
        o_col.payload.last_column  = (r_col == COL_LAST);
        if (r_col == COL_LAST) begin
            o_col.payload.entry_row0 = r_res.dot[0];
            o_col.payload.entry_row1 = r_res.dot[1];
            o_col.payload.entry_row2 = r_res.dot[2];
            o_col.payload.entry_row3 = ONE_Q;
        end else begin
            o_col.payload.entry_row0 = WORD_BITS'($signed(r_res.s[r_col]));
            o_col.payload.entry_row1 = WORD_BITS'($signed(r_res.u[r_col]));
            o_col.payload.entry_row2 = -WORD_BITS'($signed(r_res.f[r_col]));
            o_col.payload.entry_row3 = '0;
        end
    end

    `LAV_ASSERT_NEXT(a_col_step, o_col.valid && o_col.ready && !o_col.payload.last_column, o_col.valid && (o_col.payload.column_index == $past(o_col.payload.column_index) + 2'd1), "Column transfer order broken.")
    `LAV_ASSERT_NOW(a_last_col, o_col.valid, o_col.payload.last_column == (o_col.payload.column_index == COL_LAST), "Last column mark off its column.")
    `LAV_ASSERT_NEXT(a_degen_hold, o_col.valid && o_col.ready && !o_col.payload.last_column, o_col.payload.degenerate == $past(o_col.payload.degenerate), "Degenerate flag changed within a matrix.")
    `LAV_ASSERT_NEXT(a_stall_hold, r_vld[LAST] && !en, r_vld[LAST] && (r_pipe[LAST] == $past(r_pipe[LAST])), "Stalled final stage lost its item.")

endmodule

// ===== test/tb_look_at_view_matrix.sv =====
// Testbench for the look-at view matrix block: directed and random cameras checked column by column.
`timescale 1ns / 100ps

module tb;
    import lav_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    lav_stream_if #(.t_payload(t_in_item))  cam_ch ();
    lav_stream_if #(.t_payload(t_out_item)) col_ch ();

    look_at_view_matrix_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (cam_ch.sink),
        .o_col   (col_ch.source)
    );

    t_in_item  pending_cams[$];
    t_out_item expected_cols[$];
    int        error_count;
    int        cycle_count;
    bit        stim_done;
    bit        hold_off;
    bit        no_idle;
    bit        cam_taken;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint round_shift(longint v);
        logic [63:0] m;
        m = (mag64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] sat_word(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vector(input longint c[3], output longint n[3]);
        logic [63:0] m[3];
        logic [63:0] top;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(c[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 0;
            return 1'b0;
        end
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_view_matrix(input t_in_item cam);
        longint eye[3], ctr[3], up[3], fr[3], f[3], sr[3], s[3], u[3];
        longint col[4][4];
        bit flat;
        t_out_item res;
        eye = '{longint'(cam.eye_x), longint'(cam.eye_y), longint'(cam.eye_z)};
        ctr = '{longint'(cam.center_x), longint'(cam.center_y), longint'(cam.center_z)};
        up  = '{longint'(cam.up_x), longint'(cam.up_y), longint'(cam.up_z)};
        for (int i = 0; i < 3; i++) fr[i] = ctr[i] - eye[i];
        flat = !unit_vector(fr, f);
        sr[0] = f[1] * up[2] - f[2] * up[1];
        sr[1] = f[2] * up[0] - f[0] * up[2];
        sr[2] = f[0] * up[1] - f[1] * up[0];
        if (!unit_vector(sr, s)) flat = 1'b1;
        u[0] = round_shift(s[1] * f[2] - s[2] * f[1]);
        u[1] = round_shift(s[2] * f[0] - s[0] * f[2]);
        u[2] = round_shift(s[0] * f[1] - s[1] * f[0]);
        for (int k = 0; k < 3; k++) col[k] = '{s[k], u[k], -f[k], 0};
        col[3][0] = -round_shift(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
        col[3][1] = -round_shift(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
        col[3][2] = round_shift(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
        col[3][3] = longint'(1) <<< FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            res.column_index = k[1:0];
            res.entry_row0   = sat_word(col[k][0]);
            res.entry_row1   = sat_word(col[k][1]);
            res.entry_row2   = sat_word(col[k][2]);
            res.entry_row3   = sat_word(col[k][3]);
            res.degenerate   = flat;
            res.last_column  = (k[1:0] == COL_LAST);
            expected_cols.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 7) << 16;
            3: return -($urandom_range(0, 7) << 16);
            4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item make_cam(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                                          logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                          logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
        return '{ex, ey, ez, cx, cy, cz, ux, uy, uz};
    endfunction

    initial begin
        t_in_item cam;
        logic [31:0] one;
        one = 32'h0001_0000;
        pending_cams.push_back(make_cam(0, 0, one * 5, 0, 0, 0, 0, one, 0));
        pending_cams.push_back(make_cam(one, one, one, one, one, one, 0, one, 0));
        pending_cams.push_back(make_cam(0, 0, 0, 0, one, 0, 0, one, 0));
        pending_cams.push_back(make_cam(0, 0, 0, one, 0, 0, 0, 0, 0));
        pending_cams.push_back(make_cam(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_cams.push_back(make_cam(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_cams.push_back(make_cam(32'hFFFF_FFFF, 1, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                                        1, 32'hFFFF_FFFF, 1));
        pending_cams.push_back(make_cam(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_cams.push_back(make_cam(one * 3, -one * 2, one, -one, one * 4, -one * 7,
                                        0, 0, one));
        pending_cams.push_back(make_cam(0, 0, 0, one, one, 0, -one * 3, -one * 3, 0));
        for (int n = 0; n < 150; n++) begin
            for (int w = 0; w < 9; w++) cam[w*32 +: 32] = rand_word();
            if ($urandom_range(0, 19) == 0) begin
                cam.center_x = cam.eye_x;
                cam.center_y = cam.eye_y;
                cam.center_z = cam.eye_z;
            end else if ($urandom_range(0, 19) == 0) begin
                cam.up_x = cam.center_x - cam.eye_x;
                cam.up_y = cam.center_y - cam.eye_y;
                cam.up_z = cam.center_z - cam.eye_z;
            end
            pending_cams.push_back(cam);
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        cam_ch.valid = 1'b0;
        cam_ch.payload = '0;
        col_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Receiver hold-off while the sender keeps offering, then a stretch without idling.
    initial begin
        wait (i_rst_n);
        repeat (200) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
        repeat (300) @(posedge i_clk);
        no_idle = 1'b1;
        repeat (400) @(posedge i_clk);
        no_idle = 1'b0;
    end

    always @(posedge i_clk) begin
        cam_taken = i_rst_n && cam_ch.valid && cam_ch.ready;
        if (cam_taken) begin
            predict_view_matrix(cam_ch.payload);
            void'(pending_cams.pop_front());
        end
    end

    always @(negedge i_clk) begin
        #1;
        if (i_rst_n) begin
            if (!cam_ch.valid || cam_taken) begin
                if (pending_cams.size() != 0 && (no_idle || $urandom_range(0, 99) >= 27)) begin
                    cam_ch.valid <= 1'b1;
                    cam_ch.payload <= pending_cams[0];
                end else begin
                    cam_ch.valid <= 1'b0;
                end
            end
            col_ch.ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && col_ch.valid && col_ch.ready) begin
            got = col_ch.payload;
            if (expected_cols.size() == 0) begin
                report_mismatch("unexpected column", 32'(got.column_index), 0);
            end else begin
                want = expected_cols.pop_front();
                if (got.column_index != want.column_index)
                    report_mismatch("column_index", 32'(got.column_index),
                                    32'(want.column_index));
                if (got.entry_row0 != want.entry_row0)
                    report_mismatch("entry_row0", got.entry_row0, want.entry_row0);
                if (got.entry_row1 != want.entry_row1)
                    report_mismatch("entry_row1", got.entry_row1, want.entry_row1);
                if (got.entry_row2 != want.entry_row2)
                    report_mismatch("entry_row2", got.entry_row2, want.entry_row2);
                if (got.entry_row3 != want.entry_row3)
                    report_mismatch("entry_row3", got.entry_row3, want.entry_row3);
                if (got.degenerate != want.degenerate)
                    report_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
                if (got.last_column != want.last_column)
                    report_mismatch("last_column", 32'(got.last_column),
                                    32'(want.last_column));
            end
        end
    end

    initial begin
        wait (i_rst_n);
        repeat (50) @(posedge i_clk);
        while (pending_cams.size() != 0 || cam_ch.valid || expected_cols.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (stim_done) begin
            if (error_count == 0 && expected_cols.size() == 0) begin
                $display("TB_OK");
            end else begin
                $display("TB_ERROR");
            end
            $finish;
        end else if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule
